@@ rtl/core/page_framebuffer_rasterizer_core_macros.svh @@
// Assertion macros for the framebuffer rasterizer RTL
`ifndef PAGE_FRAMEBUFFER_RASTERIZER_CORE_MACROS_SVH
`define PAGE_FRAMEBUFFER_RASTERIZER_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define PFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset
`define PFR_ASSERT_NEVER(lbl, cond, msg) \
  `PFR_ASSERT(lbl, !(cond), msg)

`endif

@@ rtl/core/pfr_pkg.sv @@
// Shared types, constants and glyph ROM of the framebuffer rasterizer
package pfr_pkg;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_PLOT  = 3'd1;
  localparam logic [2:0] OP_RECT  = 3'd2;
  localparam logic [2:0] OP_GLYPH = 3'd3;
  localparam logic [2:0] OP_SEND  = 3'd4;

  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] COL_LOW_CMD   = 8'h00;
  localparam logic [7:0] COL_HIGH_CMD  = 8'h10;
  localparam int unsigned SEND_COLUMNS = 128;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_RECT,
    CMD_GLYPH,
    CMD_SEND
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [7:0] h;
    logic [2:0] slot;
    logic [2:0] page;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } bk_status_t;

  // Return {hit, slot} for a character code
  function automatic logic [3:0] glyph_slot(input logic [7:0] code);
    logic [3:0] r;
    case (code)
      8'h48: r = {1'b1, 3'd0};
      8'h69: r = {1'b1, 3'd1};
      8'h49: r = {1'b1, 3'd2};
      8'h6E: r = {1'b1, 3'd3};
      8'h66: r = {1'b1, 3'd4};
      8'h65: r = {1'b1, 3'd5};
      8'h6F: r = {1'b1, 3'd6};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] glyph_col(input logic [2:0] slot, input logic [2:0] col);
    logic [39:0] g;
    logic [7:0]  r;
    case (slot)
      3'd0: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      3'd1: g = {8'h00, 8'h40, 8'h7D, 8'h44, 8'h00};
      3'd2: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      3'd3: g = {8'h78, 8'h04, 8'h04, 8'h08, 8'h7C};
      3'd4: g = {8'h02, 8'h01, 8'h09, 8'h7E, 8'h08};
      3'd5: g = {8'h18, 8'h54, 8'h54, 8'h54, 8'h38};
      3'd6: g = {8'h38, 8'h44, 8'h44, 8'h44, 8'h38};
      default: g = 40'd0;
    endcase
    case (col)
      3'd0: r = g[7:0];
      3'd1: r = g[15:8];
      3'd2: r = g[23:16];
      3'd3: r = g[31:24];
      3'd4: r = g[39:32];
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/pfr_front.sv @@
// Command intake: classify, drop no-op commands, two-entry queue
module pfr_front
  import pfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_pos_x,
  input  logic [7:0] in_pos_y,
  input  logic [7:0] in_rect_width,
  input  logic [7:0] in_rect_height,
  input  logic [7:0] in_glyph_code,
  input  logic [7:0] in_glyph_scale,
  input  logic [2:0] in_page_index,
  input  bk_status_t bk_status,
  output logic       q_valid,
  output cmd_t       q_cmd
);

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cmd;
  logic       keep;
  logic       push;
  logic [3:0] gs;

  assign busy    = (cnt_r == 2'd2) || bk_status.init_busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_mem_r[rd_ptr_r];

  always_comb begin
    gs        = glyph_slot(in_glyph_code);
    cmd.x     = in_pos_x;
    cmd.y     = in_pos_y;
    cmd.w     = in_rect_width;
    cmd.h     = in_rect_height;
    cmd.slot  = gs[2:0];
    cmd.page  = in_page_index;
    cmd.kind  = CMD_CLEAR;
    keep      = 1'b0;
    case (in_operation)
      OP_CLEAR: begin
        keep = 1'b1;
      end
      OP_PLOT: begin
        cmd.kind = CMD_RECT;
        cmd.w    = 8'd1;
        cmd.h    = 8'd1;
        keep     = 1'b1;
      end
      OP_RECT: begin
        cmd.kind = CMD_RECT;
        keep     = (in_rect_width != 8'd0) && (in_rect_height != 8'd0);
      end
      OP_GLYPH: begin
        cmd.kind = CMD_GLYPH;
        cmd.w    = in_glyph_scale;
        cmd.h    = in_glyph_scale;
        keep     = gs[3] && (in_glyph_scale != 8'd0);
      end
      OP_SEND: begin
        cmd.kind = CMD_SEND;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    push       = start && !busy && keep;
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = bk_status.pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, bk_status.pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

@@ rtl/core/pfr_back.sv @@
// Command engine: frame store, clear, pixel read-modify-write, glyph walk, page send
`include "page_framebuffer_rasterizer_core_macros.svh"
module pfr_back
  import pfr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output bk_status_t  bk_status,
  output logic        out_strobe,
  output logic        out_frame_kind,
  output logic [63:0] out_payload,
  output logic        out_first_data,
  output logic        out_last_of_page
);

  localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int DEPTH = SCREEN_WIDTH * PAGES;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_CLEAR, S_RD, S_WR, S_GLYPH, S_SEND
  } state_t;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  state_t      state_r;
  logic [AW-1:0] clr_r;
  logic [7:0]  rx_r, ry_r, rw_r, rh_r, i_r, j_r;
  logic [7:0]  y0_r, gox_r, goy_r, scale_r;
  logic [2:0]  slot_r, gcol_r, grow_r, page_r;
  logic        gly_more_r;
  logic [AW-1:0] waddr_r;
  logic [7:0]  mask_r;
  logic [7:0]  cnt_r;
  logic        pend_r, rd_ok_r;
  logic [6:0]  pidx_r;
  logic [55:0] word_r;
  logic        pop_r;
  logic        strobe_r, kind_r, first_r, last_r;
  logic [63:0] payload_r;

  logic [7:0]    px, py;
  logic          pix_in;
  logic [AW-1:0] pix_addr;
  logic          rect_last;
  logic [7:0]    gbits;
  logic          gly_last;
  logic [6:0]    col;
  logic          send_ok;
  logic [AW-1:0] send_addr;
  logic [7:0]    cap_byte;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  assign bk_status.pop       = pop_r;
  assign bk_status.init_busy = (state_r == S_INIT);
  assign out_strobe       = strobe_r;
  assign out_frame_kind   = kind_r;
  assign out_payload      = payload_r;
  assign out_first_data   = first_r;
  assign out_last_of_page = last_r;

  always_comb begin
    px        = rx_r + i_r;
    py        = ry_r + j_r;
    pix_in    = (int'(px) < SCREEN_WIDTH) && (int'(py) < SCREEN_HEIGHT);
    pix_addr  = pix_in ? AW'(int'(py[7:3]) * SCREEN_WIDTH + int'(px)) : '0;
    rect_last = (i_r == rw_r - 8'd1) && (j_r == rh_r - 8'd1);
    gbits     = glyph_col(slot_r, gcol_r);
    gly_last  = (gcol_r == 3'd4) && (grow_r == 3'd6);
    col       = cnt_r[6:0];
    send_ok   = !cnt_r[7] && (int'(col) < SCREEN_WIDTH) && (int'(page_r) < PAGES);
    send_addr = send_ok ? AW'(int'(page_r) * SCREEN_WIDTH + int'(col)) : '0;
    cap_byte  = rd_ok_r ? rdata_r : 8'd0;
    mem_we    = 1'b0;
    mem_waddr = clr_r;
    mem_wdata = 8'd0;
    mem_raddr = '0;
    case (state_r)
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_waddr = waddr_r;
        mem_wdata = rdata_r | mask_r;
      end
      S_RD: begin
        mem_raddr = pix_addr;
      end
      S_SEND: begin
        mem_raddr = send_addr;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      clr_r    <= '0;
      pop_r    <= 1'b0;
      strobe_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      pop_r    <= 1'b0;
      strobe_r <= 1'b0;
      case (state_r)
        S_INIT, S_CLEAR: begin
          if (int'(clr_r) == DEPTH - 1) begin
            clr_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            clr_r <= clr_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (q_valid && !pop_r) begin
            pop_r      <= 1'b1;
            rx_r       <= q_cmd.x;
            ry_r       <= q_cmd.y;
            rw_r       <= q_cmd.w;
            rh_r       <= q_cmd.h;
            i_r        <= 8'd0;
            j_r        <= 8'd0;
            y0_r       <= q_cmd.y;
            gox_r      <= q_cmd.x;
            goy_r      <= q_cmd.y;
            scale_r    <= q_cmd.w;
            slot_r     <= q_cmd.slot;
            gcol_r     <= 3'd0;
            grow_r     <= 3'd0;
            page_r     <= q_cmd.page;
            gly_more_r <= 1'b0;
            case (q_cmd.kind)
              CMD_CLEAR: state_r <= S_CLEAR;
              CMD_RECT:  state_r <= S_RD;
              CMD_GLYPH: state_r <= S_GLYPH;
              CMD_SEND: begin
                strobe_r  <= 1'b1;
                kind_r    <= 1'b0;
                first_r   <= 1'b0;
                last_r    <= 1'b0;
                payload_r <= {40'd0, COL_HIGH_CMD, COL_LOW_CMD,
                              PAGE_CMD_BASE + {5'd0, q_cmd.page}};
                cnt_r     <= 8'd0;
                state_r   <= S_SEND;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_RD, S_WR: begin
          if (state_r == S_RD && pix_in) begin
            waddr_r <= pix_addr;
            mask_r  <= 8'd1 << py[2:0];
            state_r <= S_WR;
          end else begin
            if (rect_last) begin
              state_r <= gly_more_r ? S_GLYPH : S_IDLE;
            end else begin
              state_r <= S_RD;
              if (j_r == rh_r - 8'd1) begin
                j_r <= 8'd0;
                i_r <= i_r + 8'd1;
              end else begin
                j_r <= j_r + 8'd1;
              end
            end
          end
        end
        S_GLYPH: begin
          if (gbits[grow_r]) begin
            rx_r       <= gox_r;
            ry_r       <= goy_r;
            rw_r       <= scale_r;
            rh_r       <= scale_r;
            i_r        <= 8'd0;
            j_r        <= 8'd0;
            gly_more_r <= !gly_last;
            state_r    <= S_RD;
          end else if (gly_last) begin
            state_r <= S_IDLE;
          end
          if (grow_r == 3'd6) begin
            grow_r <= 3'd0;
            goy_r  <= y0_r;
            gcol_r <= gcol_r + 3'd1;
            gox_r  <= gox_r + scale_r;
          end else begin
            grow_r <= grow_r + 3'd1;
            goy_r  <= goy_r + scale_r;
          end
        end
        S_SEND: begin
          pend_r  <= !cnt_r[7];
          rd_ok_r <= send_ok;
          pidx_r  <= col;
          if (!cnt_r[7]) begin
            cnt_r <= cnt_r + 8'd1;
          end else begin
            state_r <= S_IDLE;
          end
          if (pend_r) begin
            if (pidx_r[2:0] == 3'd7) begin
              strobe_r  <= 1'b1;
              kind_r    <= 1'b1;
              first_r   <= (pidx_r[6:3] == 4'd0);
              last_r    <= (pidx_r[6:3] == 4'd15);
              payload_r <= {cap_byte, word_r};
            end else begin
              word_r[pidx_r[2:0]*8 +: 8] <= cap_byte;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `PFR_ASSERT(a_no_result_in_init, (state_r == S_INIT) |-> !out_strobe, "result during init")
  `PFR_ASSERT(a_cmd_gap, (out_strobe && !out_frame_kind) |=> !out_strobe, "chunk follows command")
  `PFR_ASSERT_NEVER(a_first_not_last, out_strobe && out_first_data && out_last_of_page, "first and last")
  `PFR_ASSERT(a_last_ends_send, out_strobe && out_last_of_page |-> state_r == S_IDLE, "send not done")

endmodule

@@ rtl/core/page_framebuffer_rasterizer_core.sv @@
// Top level of the page framebuffer rasterizer
//
// Monochrome framebuffer in page layout (one byte per column per 8-row page)
// that draws pixels, rectangles and scaled 5x7 glyphs and streams a page out.
// A command transfer happens on a rising edge with start high and busy low.
// The front queues up to two commands, so start may be issued while the
// engine is still drawing; busy rises when the queue is full. Right after
// reset the frame store is wiped one byte a cycle, all SCREEN_WIDTH *
// ceil(SCREEN_HEIGHT / 8) bytes, with busy held high. In the engine, clear
// writes every store byte in turn, set pixel / fill rectangle read and then
// write each visible pixel and skip each clipped one, a glyph walks its 35
// dots and draws a scale-by-scale rectangle for each lit dot, and send page
// reads the page column by column. Send page gives one address-command
// transfer and then 16 data
// chunks, each on the out_ ports for one cycle with out_strobe high; the
// receiver cannot stall them, so it must take every strobed cycle.
module page_framebuffer_rasterizer_core
  import pfr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_pos_x,
  input  logic [7:0]  in_pos_y,
  input  logic [7:0]  in_rect_width,
  input  logic [7:0]  in_rect_height,
  input  logic [7:0]  in_glyph_code,
  input  logic [7:0]  in_glyph_scale,
  input  logic [2:0]  in_page_index,
  output logic        out_strobe,
  output logic        out_frame_kind,
  output logic [63:0] out_payload,
  output logic        out_first_data,
  output logic        out_last_of_page
);

  bk_status_t bk_status;
  logic       q_valid;
  cmd_t       q_cmd;

  // Front: classify and queue; drops zero-size rectangles and glyphs, unknown glyph codes and unknown operations
  pfr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_glyph_code  (in_glyph_code),
    .in_glyph_scale (in_glyph_scale),
    .in_page_index  (in_page_index),
    .bk_status      (bk_status),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd)
  );

  // Back: own the frame store and carry out one command at a time
  pfr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .bk_status        (bk_status),
    .out_strobe       (out_strobe),
    .out_frame_kind   (out_frame_kind),
    .out_payload      (out_payload),
    .out_first_data   (out_first_data),
    .out_last_of_page (out_last_of_page)
  );

endmodule
